/* hdl/quaternion_vector_rotation_top_macros.svh */
// ----------------------------------------------------------------------------
// Quaternion vector rotation: assertion macros
// Shared property wrappers for the checker, clocked, disabled under reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATION_TOP_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define QVR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation: package
// Widths, pipeline stage map, shared types and rounding/saturation helpers.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int QUAT_W   = 16;              // Q1.15 quaternion parts
   localparam int VEC_W    = 24;              // Q2.22 vector components
   localparam int MAT_W    = 16;              // Q3.13 matrix entries

   localparam int QPROD_W  = 2 * QUAT_W;      // Q2.30 quaternion products
   localparam int MEXACT_W = QPROD_W + 2;     // exact matrix, 30 fraction bits
   localparam int MAT_DROP = 17;              // 30 -> 13 fraction bits
   localparam int MROUND_W = MEXACT_W + 1 - MAT_DROP;

   // matrix entry split for the vector products: signed high, unsigned low
   localparam int SPLIT    = 17;
   localparam int AHI_W    = MEXACT_W - SPLIT;
   localparam int ALO_W    = SPLIT + 1;
   localparam int PHI_W    = AHI_W + VEC_W;
   localparam int PLO_W    = ALO_W + VEC_W;
   localparam int SHI_W    = PHI_W + 2;
   localparam int SLO_W    = PLO_W + 2;

   localparam int ACC_W    = 60;              // 52 fraction bits, plus headroom
   localparam int VEC_DROP = 30;              // 52 -> 22 fraction bits
   localparam int VROUND_W = ACC_W - VEC_DROP;

   // pipeline stage map
   localparam int NUM_STAGES = 6;
   localparam int ST_PROD    = 0;             // quaternion products
   localparam int ST_MAT     = 1;             // exact matrix
   localparam int ST_PART    = 2;             // split partial products, matrix rounded
   localparam int ST_SUM     = 3;             // column sums of partials
   localparam int ST_ACC     = 4;             // recombined, rounding bias added
   localparam int ST_OUT     = 5;             // saturated result word

   typedef logic signed [QUAT_W-1:0]   quat_type;
   typedef logic signed [VEC_W-1:0]    vec_type;
   typedef logic signed [MAT_W-1:0]    mat_type;
   typedef logic signed [QPROD_W-1:0]  qprod_type;
   typedef logic signed [MEXACT_W-1:0] mexact_type;
   typedef logic signed [PHI_W-1:0]    phi_type;
   typedef logic signed [PLO_W-1:0]    plo_type;
   typedef logic signed [SHI_W-1:0]    shi_type;
   typedef logic signed [SLO_W-1:0]    slo_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

   // round to 13 fraction bits, halves up, then clamp to Q3.13
   function automatic mat_type round_mat(input mexact_type a);
      logic signed [MEXACT_W:0]   t;
      logic signed [MROUND_W-1:0] r;
      logic [MROUND_W-MAT_W:0]    top;
      t   = (MEXACT_W + 1)'(a) + (MEXACT_W + 1)'(2 ** (MAT_DROP - 1));
      r   = $signed(t[MEXACT_W:MAT_DROP]);
      top = r[MROUND_W-1:MAT_W-1];
      if ((&top) || !(|top))
         return r[MAT_W-1:0];
      else if (r[MROUND_W-1])
         return {1'b1, {(MAT_W - 1){1'b0}}};
      else
         return {1'b0, {(MAT_W - 1){1'b1}}};
   endfunction

   // drop 30 fraction bits (bias already added) and saturate to Q2.22
   function automatic vec_type sat_vec(input acc_type a);
      logic signed [VROUND_W-1:0] r;
      logic [VROUND_W-VEC_W:0]    top;
      r   = $signed(a[ACC_W-1:VEC_DROP]);
      top = r[VROUND_W-1:VEC_W-1];
      if ((&top) || !(|top))
         return r[VEC_W-1:0];
      else if (r[VROUND_W-1])
         return {1'b1, {(VEC_W - 1){1'b0}}};
      else
         return {1'b0, {(VEC_W - 1){1'b1}}};
   endfunction

endpackage

/* hdl/qvr_ctrl.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation: pipeline control
// Valid bit per stage; a stage loads when it is empty or its successor moves.
// ----------------------------------------------------------------------------
module qvr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  rsp_stall,
   output qvr_pkg::pipe_ctrl_type ctrl
);
   import qvr_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall  = reset || !load[0];
   assign ctrl.load  = load;
   assign ctrl.valid = valid_ff;

endmodule

/* hdl/qvr_dcm.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation: direction-cosine matrix
// Two stages: the ten quaternion products, then the exact nine matrix entries.
// ----------------------------------------------------------------------------
module qvr_dcm (
   input  logic                   clock,
   input  qvr_pkg::pipe_ctrl_type ctrl,
   input  qvr_pkg::quat_type      quat_x,
   input  qvr_pkg::quat_type      quat_y,
   input  qvr_pkg::quat_type      quat_z,
   input  qvr_pkg::quat_type      quat_w,
   input  qvr_pkg::vec_type       vec_x,
   input  qvr_pkg::vec_type       vec_y,
   input  qvr_pkg::vec_type       vec_z,
   output qvr_pkg::mexact_type    mat [9],
   output qvr_pkg::vec_type       vec [3]
);
   import qvr_pkg::*;

   qprod_type  xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, xz_ff, yz_ff, xw_ff, yw_ff, zw_ff;
   qprod_type  xx_in, yy_in, zz_in, ww_in, xy_in, xz_in, yz_in, xw_in, yw_in, zw_in;
   vec_type    vec_p_ff [3];
   vec_type    vec_m_ff [3];
   mexact_type mat_ff   [9];
   mexact_type mat_in   [9];

   always_comb begin
      xx_in = QPROD_W'(quat_x) * QPROD_W'(quat_x);
      yy_in = QPROD_W'(quat_y) * QPROD_W'(quat_y);
      zz_in = QPROD_W'(quat_z) * QPROD_W'(quat_z);
      ww_in = QPROD_W'(quat_w) * QPROD_W'(quat_w);
      xy_in = QPROD_W'(quat_x) * QPROD_W'(quat_y);
      xz_in = QPROD_W'(quat_x) * QPROD_W'(quat_z);
      yz_in = QPROD_W'(quat_y) * QPROD_W'(quat_z);
      xw_in = QPROD_W'(quat_x) * QPROD_W'(quat_w);
      yw_in = QPROD_W'(quat_y) * QPROD_W'(quat_w);
      zw_in = QPROD_W'(quat_z) * QPROD_W'(quat_w);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_PROD]) begin
         xx_ff       <= xx_in;
         yy_ff       <= yy_in;
         zz_ff       <= zz_in;
         ww_ff       <= ww_in;
         xy_ff       <= xy_in;
         xz_ff       <= xz_in;
         yz_ff       <= yz_in;
         xw_ff       <= xw_in;
         yw_ff       <= yw_in;
         zw_ff       <= zw_in;
         vec_p_ff[0] <= vec_x;
         vec_p_ff[1] <= vec_y;
         vec_p_ff[2] <= vec_z;
      end
   end

   // off-diagonal pairs fit in 33 bits, so doubling in 34 is exact
   always_comb begin
      mat_in[0] = MEXACT_W'(xx_ff) - MEXACT_W'(yy_ff) - MEXACT_W'(zz_ff) + MEXACT_W'(ww_ff);
      mat_in[1] = (MEXACT_W'(xy_ff) + MEXACT_W'(zw_ff)) <<< 1;
      mat_in[2] = (MEXACT_W'(xz_ff) - MEXACT_W'(yw_ff)) <<< 1;
      mat_in[3] = (MEXACT_W'(xy_ff) - MEXACT_W'(zw_ff)) <<< 1;
      mat_in[4] = MEXACT_W'(yy_ff) - MEXACT_W'(xx_ff) - MEXACT_W'(zz_ff) + MEXACT_W'(ww_ff);
      mat_in[5] = (MEXACT_W'(yz_ff) + MEXACT_W'(xw_ff)) <<< 1;
      mat_in[6] = (MEXACT_W'(xz_ff) + MEXACT_W'(yw_ff)) <<< 1;
      mat_in[7] = (MEXACT_W'(yz_ff) - MEXACT_W'(xw_ff)) <<< 1;
      mat_in[8] = MEXACT_W'(zz_ff) - MEXACT_W'(xx_ff) - MEXACT_W'(yy_ff) + MEXACT_W'(ww_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_MAT]) begin
         mat_ff   <= mat_in;
         vec_m_ff <= vec_p_ff;
      end
   end

   assign mat = mat_ff;
   assign vec = vec_m_ff;

endmodule

/* hdl/qvr_mac.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation: transpose multiply
// Each matrix entry is split high/low so every multiplier stays near 17x24;
// partials are summed per column, then recombined with the rounding bias.
// ----------------------------------------------------------------------------
module qvr_mac (
   input  logic                   clock,
   input  qvr_pkg::pipe_ctrl_type ctrl,
   input  qvr_pkg::mexact_type    mat [9],
   input  qvr_pkg::vec_type       vec [3],
   output qvr_pkg::mat_type       mat_r [9],
   output qvr_pkg::acc_type       acc [3]
);
   import qvr_pkg::*;

   logic signed [AHI_W-1:0] ahi [9];
   logic signed [ALO_W-1:0] alo [9];
   phi_type phi_in [9];
   plo_type plo_in [9];
   phi_type phi_ff [9];
   plo_type plo_ff [9];
   mat_type matr_in [9];
   mat_type matr_p_ff [9];
   mat_type matr_s_ff [9];
   mat_type matr_a_ff [9];
   shi_type shi_in [3];
   slo_type slo_in [3];
   shi_type shi_ff [3];
   slo_type slo_ff [3];
   acc_type acc_in [3];
   acc_type acc_ff [3];

   // entry 3j+i meets vector component j and feeds output column i
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            ahi[3*j+i]    = $signed(mat[3*j+i][MEXACT_W-1:SPLIT]);
            alo[3*j+i]    = $signed({1'b0, mat[3*j+i][SPLIT-1:0]});
            phi_in[3*j+i] = PHI_W'(ahi[3*j+i]) * PHI_W'(vec[j]);
            plo_in[3*j+i] = PLO_W'(alo[3*j+i]) * PLO_W'(vec[j]);
            matr_in[3*j+i] = round_mat(mat[3*j+i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_PART]) begin
         phi_ff    <= phi_in;
         plo_ff    <= plo_in;
         matr_p_ff <= matr_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shi_in[i] = SHI_W'(phi_ff[i]) + SHI_W'(phi_ff[3+i]) + SHI_W'(phi_ff[6+i]);
         slo_in[i] = SLO_W'(plo_ff[i]) + SLO_W'(plo_ff[3+i]) + SLO_W'(plo_ff[6+i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_SUM]) begin
         shi_ff    <= shi_in;
         slo_ff    <= slo_in;
         matr_s_ff <= matr_p_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = (ACC_W'(shi_ff[i]) <<< SPLIT) + ACC_W'(slo_ff[i])
                   + ACC_W'(2 ** (VEC_DROP - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_ACC]) begin
         acc_ff    <= acc_in;
         matr_a_ff <= matr_s_ff;
      end
   end

   assign mat_r = matr_a_ff;
   assign acc   = acc_ff;

endmodule

/* hdl/qvr_out.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation: output stage
// Truncates the biased sums to Q2.22 with saturation; holds the result word.
// ----------------------------------------------------------------------------
module qvr_out (
   input  logic                   clock,
   input  qvr_pkg::pipe_ctrl_type ctrl,
   input  qvr_pkg::mat_type       mat_r [9],
   input  qvr_pkg::acc_type       acc [3],
   output qvr_pkg::mat_type       mat_o [9],
   output qvr_pkg::vec_type       rot_o [3]
);
   import qvr_pkg::*;

   mat_type mat_ff [9];
   vec_type rot_ff [3];
   vec_type rot_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rot_in[i] = sat_vec(acc[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[ST_OUT]) begin
         mat_ff <= mat_r;
         rot_ff <= rot_in;
      end
   end

   assign mat_o = mat_ff;
   assign rot_o = rot_ff;

endmodule

/* hdl/quaternion_vector_rotation_top.sv */
// Throughput: one word per cycle while rsp_stall is low; six pipeline registers,
// each with a valid bit, carry an accepted request word to its response word.
// A response stall holds only the stages that are full; bubbles still close up.
// Reset (synchronous) clears the valid bits; req_stall is high while it is held.
// ----------------------------------------------------------------------------
// Quaternion vector rotation: top level
// Quaternion to 3x3 direction-cosine matrix (Q3.13) and vector rotated by its
// transpose (Q2.22, saturated), fully pipelined.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qvr_pkg::quat_type req_quat_x,
   input  qvr_pkg::quat_type req_quat_y,
   input  qvr_pkg::quat_type req_quat_z,
   input  qvr_pkg::quat_type req_quat_w,
   input  qvr_pkg::vec_type  req_vec_x,
   input  qvr_pkg::vec_type  req_vec_y,
   input  qvr_pkg::vec_type  req_vec_z,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qvr_pkg::mat_type  rsp_m00,
   output qvr_pkg::mat_type  rsp_m01,
   output qvr_pkg::mat_type  rsp_m02,
   output qvr_pkg::mat_type  rsp_m10,
   output qvr_pkg::mat_type  rsp_m11,
   output qvr_pkg::mat_type  rsp_m12,
   output qvr_pkg::mat_type  rsp_m20,
   output qvr_pkg::mat_type  rsp_m21,
   output qvr_pkg::mat_type  rsp_m22,
   output qvr_pkg::vec_type  rsp_rot_x,
   output qvr_pkg::vec_type  rsp_rot_y,
   output qvr_pkg::vec_type  rsp_rot_z
);
   import qvr_pkg::*;

   pipe_ctrl_type ctrl;
   mexact_type    mat_exact [9];
   vec_type       vec_d     [3];
   mat_type       mat_r     [9];
   acc_type       acc       [3];
   mat_type       mat_o     [9];
   vec_type       rot_o     [3];

   qvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   qvr_dcm u_dcm (
      .clock  (clock),
      .ctrl   (ctrl),
      .quat_x (req_quat_x),
      .quat_y (req_quat_y),
      .quat_z (req_quat_z),
      .quat_w (req_quat_w),
      .vec_x  (req_vec_x),
      .vec_y  (req_vec_y),
      .vec_z  (req_vec_z),
      .mat    (mat_exact),
      .vec    (vec_d)
   );

   qvr_mac u_mac (
      .clock (clock),
      .ctrl  (ctrl),
      .mat   (mat_exact),
      .vec   (vec_d),
      .mat_r (mat_r),
      .acc   (acc)
   );

   qvr_out u_out (
      .clock (clock),
      .ctrl  (ctrl),
      .mat_r (mat_r),
      .acc   (acc),
      .mat_o (mat_o),
      .rot_o (rot_o)
   );

   assign rsp_valid = ctrl.valid[ST_OUT];
   assign rsp_m00   = mat_o[0];
   assign rsp_m01   = mat_o[1];
   assign rsp_m02   = mat_o[2];
   assign rsp_m10   = mat_o[3];
   assign rsp_m11   = mat_o[4];
   assign rsp_m12   = mat_o[5];
   assign rsp_m20   = mat_o[6];
   assign rsp_m21   = mat_o[7];
   assign rsp_m22   = mat_o[8];
   assign rsp_rot_x = rot_o[0];
   assign rsp_rot_y = rot_o[1];
   assign rsp_rot_z = rot_o[2];

endmodule

/* hdl/qvr_checker.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation: port checker
// Watches the top-level ports for latency, zero-vector, reset and response-hold behaviour.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotation_top_macros.svh"

module qvr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input qvr_pkg::vec_type  req_vec_x,
   input qvr_pkg::vec_type  req_vec_y,
   input qvr_pkg::vec_type  req_vec_z,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input qvr_pkg::mat_type  rsp_m00,
   input qvr_pkg::mat_type  rsp_m11,
   input qvr_pkg::mat_type  rsp_m22,
   input qvr_pkg::vec_type  rsp_rot_x,
   input qvr_pkg::vec_type  rsp_rot_y,
   input qvr_pkg::vec_type  rsp_rot_z
);
   import qvr_pkg::*;

   localparam logic [2:0] FREE_MAX = 3'(NUM_STAGES - 1);

   // consecutive edges with the response side free and out of reset
   logic [2:0] free_cnt_ff;
   logic [2:0] free_cnt_in;
   logic       req_take;
   logic       zero_take;

   always_comb begin
      free_cnt_in = free_cnt_ff;
      if (rsp_stall) begin
         free_cnt_in = '0;
      end else if (free_cnt_ff != FREE_MAX) begin
         free_cnt_in = free_cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_cnt_ff <= '0;
      end else begin
         free_cnt_ff <= free_cnt_in;
      end
   end

   assign req_take  = req_valid && !req_stall;
   assign zero_take = req_take && (req_vec_x == '0) && (req_vec_y == '0)
                      && (req_vec_z == '0);

   `QVR_ASSERT_SAME(a_latency, clock, reset,
      $past(req_take, NUM_STAGES) && (free_cnt_ff == FREE_MAX), rsp_valid,
      "word accepted with a free response side did not emerge after six cycles")

   `QVR_ASSERT_SAME(a_zero_vec, clock, reset,
      $past(zero_take, NUM_STAGES) && (free_cnt_ff == FREE_MAX),
      (rsp_rot_x == '0) && (rsp_rot_y == '0) && (rsp_rot_z == '0),
      "zero vector did not rotate to zero")

   `QVR_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid,
      "response word present straight after reset")

   `QVR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_rot_x) && $stable(rsp_rot_y) && $stable(rsp_rot_z)
      && $stable(rsp_m00) && $stable(rsp_m11) && $stable(rsp_m22),
      "stalled response word dropped or changed")

endmodule

bind quaternion_vector_rotation_top qvr_checker u_qvr_checker (.*);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation: testbench
// Drives quaternion/vector words through the block with bursty requests and a
// patterned response stall. Each accepted word is predicted in 64-bit integer
// arithmetic, and every response is checked field by field against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
   qvr_pkg::quat_type [3:0] quat;   // x, y, z, w
   qvr_pkg::vec_type  [2:0] vec;    // x, y, z
} rot_request_t;

typedef struct packed {
   qvr_pkg::mat_type [8:0] mat;     // row-major, mat[3*row + col]
   qvr_pkg::vec_type [2:0] rot;     // x, y, z
} rot_result_t;

class rotation_scoreboard;
   localparam int REPORT_LINES = 100;

   rot_result_t pending[$];
   int          fail_count;

   function new();
      fail_count = 0;
   endfunction

   task report(input string msg);
      if (fail_count < REPORT_LINES)
         $display("ERROR: %s", msg);
      fail_count++;
   endtask

   // round to nearest with halves towards plus infinity
   function longint round_half_up(input longint v, input int unsigned sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo)
         return lo;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function rot_result_t predict_rotation(input rot_request_t r);
      rot_result_t res;
      longint x, y, z, w;
      longint xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
      longint s [3];
      longint a [9];
      longint acc;
      x = $signed(r.quat[0]);
      y = $signed(r.quat[1]);
      z = $signed(r.quat[2]);
      w = $signed(r.quat[3]);
      for (int j = 0; j < 3; j++)
         s[j] = $signed(r.vec[j]);
      xx = x * x;  yy = y * y;  zz = z * z;  ww = w * w;
      xy = x * y;  xz = x * z;  yz = y * z;
      xw = x * w;  yw = y * w;  zw = z * w;
      // exact direction-cosine matrix, 30 fraction bits
      a[0] = xx - yy - zz + ww;
      a[1] = 2 * (xy + zw);
      a[2] = 2 * (xz - yw);
      a[3] = 2 * (xy - zw);
      a[4] = -xx + yy - zz + ww;
      a[5] = 2 * (yz + xw);
      a[6] = 2 * (xz + yw);
      a[7] = 2 * (yz - xw);
      a[8] = -xx - yy + zz + ww;
      for (int k = 0; k < 9; k++)
         res.mat[k] = qvr_pkg::mat_type'(clamp(round_half_up(a[k], 17), -32768, 32767));
      // transpose product from the unrounded matrix, 52 fraction bits
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++)
            acc += a[3 * j + i] * s[j];
         res.rot[i] = qvr_pkg::vec_type'(clamp(round_half_up(acc, 30), -8388608, 8388607));
      end
      return res;
   endfunction

   function void note_request(input rot_request_t r);
      pending.push_back(predict_rotation(r));
   endfunction

   function int outstanding();
      return pending.size();
   endfunction

   task check_result(input rot_result_t got);
      rot_result_t want;
      if (pending.size() == 0) begin
         report("response word with nothing outstanding");
         return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++)
         if (got.mat[k] !== want.mat[k])
            report($sformatf("m%0d%0d got %0d expected %0d",
                             k / 3, k % 3, got.mat[k], want.mat[k]));
      for (int i = 0; i < 3; i++)
         if (got.rot[i] !== want.rot[i])
            report($sformatf("rot[%0d] got %0d expected %0d", i, got.rot[i], want.rot[i]));
   endtask
endclass

module tb_top;
   localparam int RANDOM_WORDS   = 2000;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 12;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         rsp_stall = 1'b0;
   rot_request_t req_word  = '0;
   logic         req_stall;
   logic         rsp_valid;
   wire rot_result_t rsp_word;

   rotation_scoreboard sb;
   stall_mode_t        stall_mode  = STALL_NONE;
   int                 stall_phase = 0;
   int                 quiet_cycles = 0;

   quaternion_vector_rotation_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_quat_x (req_word.quat[0]),
      .req_quat_y (req_word.quat[1]),
      .req_quat_z (req_word.quat[2]),
      .req_quat_w (req_word.quat[3]),
      .req_vec_x  (req_word.vec[0]),
      .req_vec_y  (req_word.vec[1]),
      .req_vec_z  (req_word.vec[2]),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_m00    (rsp_word.mat[0]),
      .rsp_m01    (rsp_word.mat[1]),
      .rsp_m02    (rsp_word.mat[2]),
      .rsp_m10    (rsp_word.mat[3]),
      .rsp_m11    (rsp_word.mat[4]),
      .rsp_m12    (rsp_word.mat[5]),
      .rsp_m20    (rsp_word.mat[6]),
      .rsp_m21    (rsp_word.mat[7]),
      .rsp_m22    (rsp_word.mat[8]),
      .rsp_rot_x  (rsp_word.rot[0]),
      .rsp_rot_y  (rsp_word.rot[1]),
      .rsp_rot_z  (rsp_word.rot[2])
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // accepted request and response words, sampled with pre-edge values
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_word);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_word);
   end

   // response stall: mode held for a random stretch, then reselected
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  <= stall_mode_t'($urandom_range(0, 3));
         stall_phase <= $urandom_range(50, 300);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_phase % 7) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("quaternion_vector_rotation_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic rot_request_t make_request(input int x, input int y, input int z,
                                                 input int w, input int vx, input int vy,
                                                 input int vz);
      rot_request_t r;
      r.quat[0] = qvr_pkg::quat_type'(x);
      r.quat[1] = qvr_pkg::quat_type'(y);
      r.quat[2] = qvr_pkg::quat_type'(z);
      r.quat[3] = qvr_pkg::quat_type'(w);
      r.vec[0]  = qvr_pkg::vec_type'(vx);
      r.vec[1]  = qvr_pkg::vec_type'(vy);
      r.vec[2]  = qvr_pkg::vec_type'(vz);
      return r;
   endfunction

   // bias towards the ends of the range and small magnitudes
   function automatic logic [31:0] pick_field(input int unsigned width);
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = 32'(1) << (width - 1);
         1:       v = (32'(1) << (width - 1)) - 1;
         2:       v = 32'($urandom_range(0, 8)) - 32'd4;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic rot_request_t random_request();
      rot_request_t r;
      for (int k = 0; k < 4; k++)
         r.quat[k] = qvr_pkg::quat_type'(pick_field(qvr_pkg::QUAT_W));
      for (int j = 0; j < 3; j++)
         r.vec[j] = qvr_pkg::vec_type'(pick_field(qvr_pkg::VEC_W));
      return r;
   endfunction

   task automatic drive_request(input rot_request_t w);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic idle_for(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.outstanding() != 0);
   endtask

   initial begin
      int sent;
      int burst;
      bit paused;
      sb     = new();
      sent   = 0;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      drive_request(make_request(0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(0, 0, 0, 32767, 8388607, -8388608, 12345));
      drive_request(make_request(0, 0, 0, -32768, 8388607, 8388607, 8388607));
      drive_request(make_request(-32768, 0, 0, 0, -8388608, 8388607, -8388608));
      drive_request(make_request(0, 32767, 0, 0, 8388607, -8388608, 8388607));
      drive_request(make_request(0, 0, -32768, 0, -8388608, -8388608, 8388607));
      // every part at -1.0: three off-diagonal entries reach +4.0 and the vector saturates
      drive_request(make_request(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607));
      drive_request(make_request(-32768, -32768, -32768, -32768,
                                 -8388608, -8388608, -8388608));
      drive_request(make_request(32767, 32767, 32767, 32767, 8388607, 8388607, 8388607));
      drive_request(make_request(-32768, 32767, -32768, 32767, 8388607, -8388608, 8388607));
      drive_request(make_request(0, -32768, -32768, 0, 8388607, 8388607, -8388608));
      // matrix entries sitting exactly on a rounding half, both signs
      drive_request(make_request(128, 256, 0, 0, 0, 0, 0));
      drive_request(make_request(-128, 256, 0, 0, 0, 0, 0));
      // rotated components sitting exactly on a rounding half, both signs
      drive_request(make_request(0, 0, 0, 128, 32768, 32768, 32768));
      drive_request(make_request(0, 0, 0, 128, -32768, -32768, -32768));
      // unit quaternion, and an unnormalised small one
      drive_request(make_request(16384, 16384, 16384, 16384, 4194304, -4194304, 1));
      drive_request(make_request(3, -5, 7, -2, -1, 1, -8388608));

      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
            drive_request(random_request());
            sent++;
         end
         if (!paused && sent >= RANDOM_WORDS / 2) begin
            drain_results();
            paused = 1'b1;
         end else if ($urandom_range(0, 2) != 0) begin
            idle_for($urandom_range(1, 8));
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report($sformatf("%0d word(s) never returned", sb.outstanding()));
      if (sb.fail_count == 0)
         $display("quaternion_vector_rotation_top verification clean");
      else
         $display("quaternion_vector_rotation_top verification failed");
      $finish;
   end
endmodule

/* files.f */
+incdir+hdl
hdl/qvr_pkg.sv
hdl/qvr_ctrl.sv
hdl/qvr_dcm.sv
hdl/qvr_mac.sv
hdl/qvr_out.sv
hdl/quaternion_vector_rotation_top.sv
hdl/qvr_checker.sv
verif/tb_top.sv
